// File: design/mips_subset_decoder_macros.svh
// ----------------------------------------------------------------------------
// MIPS subset decoder assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef MIPS_SUBSET_DECODER_MACROS_SVH
`define MIPS_SUBSET_DECODER_MACROS_SVH

// Same-cycle implication: whenever ANTE holds, CONS holds in that cycle.
`define MSD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: whenever ANTE holds, CONS holds in the next cycle.
`define MSD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/msd_pkg.sv
// ----------------------------------------------------------------------------
// MIPS subset decoder package
// Instruction kind codes, opcode and function codes, register indexes and
// reset values shared by the decoder files.
// ----------------------------------------------------------------------------
package msd_pkg;

	typedef logic [4:0]  kind_t;
	typedef logic [5:0]  opcode_t;
	typedef logic [5:0]  funct_t;
	typedef logic [31:0] word_t;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		REG_START_ADDRESS  = 1'b0,
		REG_DATA_THRESHOLD = 1'b1
	} cfg_reg_t;

	localparam word_t START_ADDRESS_RESET  = 32'd596;
	localparam word_t DATA_THRESHOLD_RESET = 32'd700;
	localparam word_t ADDRESS_STEP         = 32'd4;

	// Result kinds.
	localparam kind_t KIND_UNKNOWN = 5'd0;
	localparam kind_t KIND_ADDI    = 5'd1;
	localparam kind_t KIND_ADDIU   = 5'd2;
	localparam kind_t KIND_SW      = 5'd3;
	localparam kind_t KIND_LW      = 5'd4;
	localparam kind_t KIND_J       = 5'd5;
	localparam kind_t KIND_BEQ     = 5'd6;
	localparam kind_t KIND_BNE     = 5'd7;
	localparam kind_t KIND_BGEZ    = 5'd8;
	localparam kind_t KIND_BGTZ    = 5'd9;
	localparam kind_t KIND_BLEZ    = 5'd10;
	localparam kind_t KIND_BLTZ    = 5'd11;
	localparam kind_t KIND_BREAK   = 5'd12;
	localparam kind_t KIND_SLT     = 5'd13;
	localparam kind_t KIND_SLTI    = 5'd14;
	localparam kind_t KIND_SLTU    = 5'd15;
	localparam kind_t KIND_SLL     = 5'd16;
	localparam kind_t KIND_SRL     = 5'd17;
	localparam kind_t KIND_SRA     = 5'd18;
	localparam kind_t KIND_SUB     = 5'd19;
	localparam kind_t KIND_SUBU    = 5'd20;
	localparam kind_t KIND_ADD     = 5'd21;
	localparam kind_t KIND_ADDU    = 5'd22;
	localparam kind_t KIND_AND     = 5'd23;
	localparam kind_t KIND_OR      = 5'd24;
	localparam kind_t KIND_XOR     = 5'd25;
	localparam kind_t KIND_NOR     = 5'd26;
	localparam kind_t KIND_NOP     = 5'd27;
	localparam kind_t KIND_DATA    = 5'd28;

	// Primary opcodes.
	localparam opcode_t OP_SPECIAL = 6'b000000;
	localparam opcode_t OP_REGIMM  = 6'b000001;
	localparam opcode_t OP_J       = 6'b000010;
	localparam opcode_t OP_BEQ     = 6'b000100;
	localparam opcode_t OP_BNE     = 6'b000101;
	localparam opcode_t OP_BLEZ    = 6'b000110;
	localparam opcode_t OP_BGTZ    = 6'b000111;
	localparam opcode_t OP_ADDI    = 6'b001000;
	localparam opcode_t OP_ADDIU   = 6'b001001;
	localparam opcode_t OP_SLTI    = 6'b001010;
	localparam opcode_t OP_LW      = 6'b100011;
	localparam opcode_t OP_SW      = 6'b101011;

	// REGIMM rt selectors.
	localparam logic [4:0] RT_BLTZ = 5'd0;
	localparam logic [4:0] RT_BGEZ = 5'd1;

	// SPECIAL function codes.
	localparam funct_t FN_SLL   = 6'b000000;
	localparam funct_t FN_SRL   = 6'b000010;
	localparam funct_t FN_SRA   = 6'b000011;
	localparam funct_t FN_BREAK = 6'b001101;
	localparam funct_t FN_ADD   = 6'b100000;
	localparam funct_t FN_ADDU  = 6'b100001;
	localparam funct_t FN_SUB   = 6'b100010;
	localparam funct_t FN_SUBU  = 6'b100011;
	localparam funct_t FN_AND   = 6'b100100;
	localparam funct_t FN_OR    = 6'b100101;
	localparam funct_t FN_XOR   = 6'b100110;
	localparam funct_t FN_NOR   = 6'b100111;
	localparam funct_t FN_SLT   = 6'b101010;
	localparam funct_t FN_SLTU  = 6'b101011;

endpackage

// File: design/msd_word_if.sv
// ----------------------------------------------------------------------------
// Instruction word channel
// Valid/ready channel carrying one raw 32-bit instruction word per item.
// ----------------------------------------------------------------------------
interface msd_word_if;
	logic        valid;
	logic        ready;
	logic [31:0] instruction_word;

	modport source (output valid, output instruction_word, input ready);
	modport sink   (input valid, input instruction_word, output ready);
endinterface

// File: design/msd_result_if.sv
// ----------------------------------------------------------------------------
// Decode result channel
// Valid/ready channel carrying one decoded result per item.
// ----------------------------------------------------------------------------
interface msd_result_if;
	logic               valid;
	logic               ready;
	logic        [4:0]  kind;
	logic        [31:0] word_address;
	logic        [4:0]  rs_field;
	logic        [4:0]  rt_field;
	logic        [4:0]  rd_field;
	logic        [4:0]  shift_amount;
	logic signed [15:0] immediate;
	logic signed [17:0] branch_offset;
	logic        [31:0] jump_target;
	logic signed [31:0] data_value;

	modport source (
		output valid, output kind, output word_address, output rs_field,
		output rt_field, output rd_field, output shift_amount, output immediate,
		output branch_offset, output jump_target, output data_value,
		input ready
	);
	modport sink (
		input valid, input kind, input word_address, input rs_field,
		input rt_field, input rd_field, input shift_amount, input immediate,
		input branch_offset, input jump_target, input data_value,
		output ready
	);
endinterface

// File: design/msd_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and its write data.
// ----------------------------------------------------------------------------
interface msd_cfg_if;
	logic        valid;
	logic        ready;
	logic [0:0]  index;
	logic [31:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/msd_classify.sv
// ----------------------------------------------------------------------------
// MIPS subset instruction classifier
// Combinational mapping of one instruction word to its instruction kind.
// ----------------------------------------------------------------------------
module msd_classify (
	input  msd_pkg::word_t word,
	output msd_pkg::kind_t kind
);

	msd_pkg::opcode_t opcode;
	msd_pkg::funct_t  funct;
	logic [4:0]       rt;
	logic [4:0]       rd;
	logic [4:0]       sa;
	msd_pkg::kind_t   special_kind;
	msd_pkg::kind_t   rd_kind;

	assign opcode = word[31:26];
	assign rt     = word[20:16];
	assign rd     = word[15:11];
	assign sa     = word[10:6];
	assign funct  = word[5:0];

	// Register-format operations that need a nonzero destination.
	always_comb begin
		case (funct)
			msd_pkg::FN_SRL:  rd_kind = msd_pkg::KIND_SRL;
			msd_pkg::FN_SRA:  rd_kind = msd_pkg::KIND_SRA;
			msd_pkg::FN_SUB:  rd_kind = msd_pkg::KIND_SUB;
			msd_pkg::FN_SUBU: rd_kind = msd_pkg::KIND_SUBU;
			msd_pkg::FN_ADD:  rd_kind = msd_pkg::KIND_ADD;
			msd_pkg::FN_ADDU: rd_kind = msd_pkg::KIND_ADDU;
			msd_pkg::FN_AND:  rd_kind = msd_pkg::KIND_AND;
			msd_pkg::FN_OR:   rd_kind = msd_pkg::KIND_OR;
			msd_pkg::FN_XOR:  rd_kind = msd_pkg::KIND_XOR;
			msd_pkg::FN_NOR:  rd_kind = msd_pkg::KIND_NOR;
			default:          rd_kind = msd_pkg::KIND_UNKNOWN;
		endcase
	end

	always_comb begin
		case (funct)
			msd_pkg::FN_BREAK: special_kind = msd_pkg::KIND_BREAK;
			msd_pkg::FN_SLT:   special_kind = msd_pkg::KIND_SLT;
			msd_pkg::FN_SLTU:  special_kind = msd_pkg::KIND_SLTU;
			msd_pkg::FN_SLL: begin
				// An all-zero shift of register zero is the canonical no-op.
				if (rt != 5'd0 || rd != 5'd0 || sa != 5'd0) begin
					special_kind = msd_pkg::KIND_SLL;
				end else begin
					special_kind = msd_pkg::KIND_NOP;
				end
			end
			default: begin
				if (rd == 5'd0) begin
					special_kind = msd_pkg::KIND_UNKNOWN;
				end else begin
					special_kind = rd_kind;
				end
			end
		endcase
	end

	always_comb begin
		case (opcode)
			msd_pkg::OP_ADDI:    kind = msd_pkg::KIND_ADDI;
			msd_pkg::OP_ADDIU:   kind = msd_pkg::KIND_ADDIU;
			msd_pkg::OP_SW:      kind = msd_pkg::KIND_SW;
			msd_pkg::OP_LW:      kind = msd_pkg::KIND_LW;
			msd_pkg::OP_J:       kind = msd_pkg::KIND_J;
			msd_pkg::OP_BEQ:     kind = msd_pkg::KIND_BEQ;
			msd_pkg::OP_BNE:     kind = msd_pkg::KIND_BNE;
			msd_pkg::OP_BGTZ:    kind = msd_pkg::KIND_BGTZ;
			msd_pkg::OP_BLEZ:    kind = msd_pkg::KIND_BLEZ;
			msd_pkg::OP_SLTI:    kind = msd_pkg::KIND_SLTI;
			msd_pkg::OP_SPECIAL: kind = special_kind;
			msd_pkg::OP_REGIMM: begin
				case (rt)
					msd_pkg::RT_BGEZ: kind = msd_pkg::KIND_BGEZ;
					msd_pkg::RT_BLTZ: kind = msd_pkg::KIND_BLTZ;
					default:          kind = msd_pkg::KIND_UNKNOWN;
				endcase
			end
			default: kind = msd_pkg::KIND_UNKNOWN;
		endcase
	end

endmodule

// File: design/mips_subset_decoder.sv
// ----------------------------------------------------------------------------
// MIPS subset decoder
// Decodes a stream of instruction words with running addresses; after BREAK
// the stream is treated as data words.
// ----------------------------------------------------------------------------
// Usage:
// Words arrive on the insn channel, one item per valid/ready handshake, and
// each produces exactly one item on the result channel, in order. The word
// is given its address when it is accepted: start_address for the first word
// after reset or after start_address is written, then plus 4 per word.
// An accepted word moves from the input register into the result register,
// which drives result valid. Throughput is one item per cycle; both registers
// advance together, so a new word is taken every cycle while the receiver
// keeps ready high. When the receiver stalls, the result register holds and
// the input register fills; insn ready drops only when both are full.
// Configuration writes on cfg are always ready and take effect in the cycle
// after the handshake; they are meant for idle periods. Reset clears both
// pipeline stages and the BREAK flag, and restores start_address to 596 and
// data_threshold to 700.
// ----------------------------------------------------------------------------
`include "mips_subset_decoder_macros.svh"

module mips_subset_decoder (
	input  logic          clk,
	input  logic          arst_n,
	msd_word_if.sink      insn,
	msd_result_if.source  result,
	msd_cfg_if.sink       cfg
);

	// Input stage: the accepted word and the address it was given.
	logic           valid_s1;
	msd_pkg::word_t word_s1;
	msd_pkg::word_t addr_s1;

	// Result stage.
	logic               valid_s2;
	msd_pkg::kind_t     kind_s2;
	msd_pkg::word_t     addr_s2;
	logic        [4:0]  rs_s2;
	logic        [4:0]  rt_s2;
	logic        [4:0]  rd_s2;
	logic        [4:0]  sa_s2;
	logic signed [15:0] imm_s2;
	logic signed [17:0] boff_s2;
	msd_pkg::word_t     jtgt_s2;
	logic signed [31:0] data_s2;

	// Architectural state and configuration.
	msd_pkg::word_t current_address_q;
	msd_pkg::word_t data_threshold_q;
	logic           break_seen_q;

	logic           insn_accept;
	logic           adv_s1;
	msd_pkg::kind_t cls_kind;
	logic           cfg_write;

	// The result register is free when empty or being drained this cycle.
	assign adv_s1      = valid_s1 && (!valid_s2 || result.ready);
	assign insn.ready  = !valid_s1 || adv_s1;
	assign insn_accept = insn.valid && insn.ready;
	assign cfg.ready   = 1'b1;
	assign cfg_write   = cfg.valid && cfg.ready;

	msd_classify u_classify (
		.word (word_s1),
		.kind (cls_kind)
	);

	// Address counter and configuration registers. Writing start_address
	// restarts numbering at the new value; the BREAK flag is left alone.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_address_q <= msd_pkg::START_ADDRESS_RESET;
			data_threshold_q  <= msd_pkg::DATA_THRESHOLD_RESET;
		end else begin
			if (insn_accept) begin
				current_address_q <= current_address_q + msd_pkg::ADDRESS_STEP;
			end
			if (cfg_write) begin
				case (msd_pkg::cfg_reg_t'(cfg.index))
					msd_pkg::REG_START_ADDRESS:  current_address_q <= cfg.data;
					msd_pkg::REG_DATA_THRESHOLD: data_threshold_q  <= cfg.data;
					default: ;
				endcase
			end
		end
	end

	// Input stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (insn_accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (insn_accept) begin
			word_s1 <= insn.instruction_word;
			addr_s1 <= current_address_q;
		end
	end

	// The BREAK flag is kept at the decode point: words are decoded strictly
	// in order as they leave the input stage, so the word right after a
	// BREAK already sees the flag set.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			break_seen_q <= 1'b0;
		end else if (adv_s1 && !break_seen_q && cls_kind == msd_pkg::KIND_BREAK) begin
			break_seen_q <= 1'b1;
		end
	end

	// Result stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// Result payload. Data words report only their value, and only when the
	// address is strictly above the threshold; instruction words report the
	// raw field decode whatever their kind.
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			addr_s2 <= addr_s1;
			if (break_seen_q) begin
				kind_s2 <= msd_pkg::KIND_DATA;
				rs_s2   <= '0;
				rt_s2   <= '0;
				rd_s2   <= '0;
				sa_s2   <= '0;
				imm_s2  <= '0;
				boff_s2 <= '0;
				jtgt_s2 <= '0;
				data_s2 <= (addr_s1 > data_threshold_q) ? signed'(word_s1) : '0;
			end else begin
				kind_s2 <= cls_kind;
				rs_s2   <= word_s1[25:21];
				rt_s2   <= word_s1[20:16];
				rd_s2   <= word_s1[15:11];
				sa_s2   <= word_s1[10:6];
				imm_s2  <= signed'(word_s1[15:0]);
				boff_s2 <= signed'({word_s1[15:0], 2'b00});
				jtgt_s2 <= {addr_s1[31:28], word_s1[25:0], 2'b00};
				data_s2 <= '0;
			end
		end
	end

	assign result.valid         = valid_s2;
	assign result.kind          = kind_s2;
	assign result.word_address  = addr_s2;
	assign result.rs_field      = rs_s2;
	assign result.rt_field      = rt_s2;
	assign result.rd_field      = rd_s2;
	assign result.shift_amount  = sa_s2;
	assign result.immediate     = imm_s2;
	assign result.branch_offset = boff_s2;
	assign result.jump_target   = jtgt_s2;
	assign result.data_value    = data_s2;

	// A data result can only exist once the BREAK flag is up.
	`MSD_ASSERT_SAME(a_data_after_break, valid_s2 && kind_s2 == msd_pkg::KIND_DATA, break_seen_q, "data result without BREAK")
	// Decoding a BREAK word sets the flag for the following word.
	`MSD_ASSERT_NEXT(a_break_sets_flag, adv_s1 && !break_seen_q && cls_kind == msd_pkg::KIND_BREAK, break_seen_q, "BREAK did not set flag")
	// The flag never clears outside reset.
	`MSD_ASSERT_SAME(a_break_sticky, 1'b1, !$fell(break_seen_q), "BREAK flag cleared")
	// Each accepted word advances the address by one word.
	`MSD_ASSERT_NEXT(a_addr_step, insn_accept && !cfg_write, current_address_q == $past(current_address_q) + msd_pkg::ADDRESS_STEP, "address did not step")

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MIPS subset decoder testbench
// Drives instruction words through the decoder with bursty valid and a
// stalling result receiver, predicts every decode result and compares it
// field by field, then switches the stream into data mode with BREAK and
// sweeps the data threshold and start address across their extremes.
// ----------------------------------------------------------------------------
module testbench;

	// Two register stages between acceptance and result; used for the quiet
	// period before register writes and at the end of the run.
	localparam int PIPE_LATENCY = 2;
	localparam int PRESSURE_HOLD = 80;

	// One expected result item, at the widths of the result channel.
	typedef struct {
		msd_pkg::kind_t     kind;
		msd_pkg::word_t     word_address;
		logic        [4:0]  rs_field;
		logic        [4:0]  rt_field;
		logic        [4:0]  rd_field;
		logic        [4:0]  shift_amount;
		logic signed [15:0] immediate;
		logic signed [17:0] branch_offset;
		msd_pkg::word_t     jump_target;
		logic signed [31:0] data_value;
	} decode_result_t;

	typedef enum int {RX_STEADY, RX_RANDOM, RX_PERIODIC} rx_mode_t;

	logic clk;
	logic arst_n;

	msd_word_if   insn ();
	msd_result_if result ();
	msd_cfg_if    cfg ();

	mips_subset_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.insn   (insn),
		.result (result),
		.cfg    (cfg)
	);

	// Our own copy of the decoder state and its configuration.
	logic           model_break_seen   = 1'b0;
	msd_pkg::word_t model_next_address = msd_pkg::START_ADDRESS_RESET;
	msd_pkg::word_t model_threshold    = msd_pkg::DATA_THRESHOLD_RESET;

	// Results predicted for accepted words, oldest first.
	decode_result_t pending_results [$];

	int error_count     = 0;
	int results_checked = 0;
	int decoded_words   = 0;
	int data_words      = 0;
	int data_above      = 0;
	int register_writes = 0;

	// Sender burst state and the receiver hold-off request.
	int burst_left   = 0;
	bit no_gaps      = 1'b0;
	int hold_request = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// The run ends here if the decoder stops making progress.
	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end

	// Classifies an instruction word the way the decoder is specified to,
	// before any BREAK has been seen.
	function automatic msd_pkg::kind_t classify_word(input msd_pkg::word_t w);
		msd_pkg::opcode_t op = w[31:26];
		logic [4:0]       rt = w[20:16];
		logic [4:0]       rd = w[15:11];
		logic [4:0]       sa = w[10:6];
		msd_pkg::funct_t  fn = w[5:0];
		case (op)
			msd_pkg::OP_ADDI:  return msd_pkg::KIND_ADDI;
			msd_pkg::OP_ADDIU: return msd_pkg::KIND_ADDIU;
			msd_pkg::OP_SW:    return msd_pkg::KIND_SW;
			msd_pkg::OP_LW:    return msd_pkg::KIND_LW;
			msd_pkg::OP_J:     return msd_pkg::KIND_J;
			msd_pkg::OP_BEQ:   return msd_pkg::KIND_BEQ;
			msd_pkg::OP_BNE:   return msd_pkg::KIND_BNE;
			msd_pkg::OP_BGTZ:  return msd_pkg::KIND_BGTZ;
			msd_pkg::OP_BLEZ:  return msd_pkg::KIND_BLEZ;
			msd_pkg::OP_SLTI:  return msd_pkg::KIND_SLTI;
			msd_pkg::OP_REGIMM: begin
				if (rt == msd_pkg::RT_BGEZ) return msd_pkg::KIND_BGEZ;
				if (rt == msd_pkg::RT_BLTZ) return msd_pkg::KIND_BLTZ;
				return msd_pkg::KIND_UNKNOWN;
			end
			msd_pkg::OP_SPECIAL: begin
				// BREAK, SLT and SLTU decode from the function code alone;
				// function zero is a shift unless every field it uses is zero.
				case (fn)
					msd_pkg::FN_BREAK: return msd_pkg::KIND_BREAK;
					msd_pkg::FN_SLT:   return msd_pkg::KIND_SLT;
					msd_pkg::FN_SLTU:  return msd_pkg::KIND_SLTU;
					msd_pkg::FN_SLL:
						return (rt != 5'd0 || rd != 5'd0 || sa != 5'd0) ?
							msd_pkg::KIND_SLL : msd_pkg::KIND_NOP;
					default: ;
				endcase
				// The remaining register forms need a nonzero destination.
				if (rd == 5'd0) return msd_pkg::KIND_UNKNOWN;
				case (fn)
					msd_pkg::FN_SRL:  return msd_pkg::KIND_SRL;
					msd_pkg::FN_SRA:  return msd_pkg::KIND_SRA;
					msd_pkg::FN_SUB:  return msd_pkg::KIND_SUB;
					msd_pkg::FN_SUBU: return msd_pkg::KIND_SUBU;
					msd_pkg::FN_ADD:  return msd_pkg::KIND_ADD;
					msd_pkg::FN_ADDU: return msd_pkg::KIND_ADDU;
					msd_pkg::FN_AND:  return msd_pkg::KIND_AND;
					msd_pkg::FN_OR:   return msd_pkg::KIND_OR;
					msd_pkg::FN_XOR:  return msd_pkg::KIND_XOR;
					msd_pkg::FN_NOR:  return msd_pkg::KIND_NOR;
					default: return msd_pkg::KIND_UNKNOWN;
				endcase
			end
			default: return msd_pkg::KIND_UNKNOWN;
		endcase
	endfunction

	function automatic msd_pkg::word_t itype(input msd_pkg::opcode_t op,
			input logic [4:0] rs, input logic [4:0] rt, input logic [15:0] imm);
		return {op, rs, rt, imm};
	endfunction

	function automatic msd_pkg::word_t rtype(input logic [4:0] rs, input logic [4:0] rt,
			input logic [4:0] rd, input logic [4:0] sa, input msd_pkg::funct_t fn);
		return {msd_pkg::OP_SPECIAL, rs, rt, rd, sa, fn};
	endfunction

	// Mostly well-formed instructions with random fields, some pure noise.
	// BREAK is never produced here, since it would end decode mode for good.
	function automatic msd_pkg::word_t random_instruction();
		msd_pkg::word_t w = $urandom();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				case ($urandom_range(0, 9))
					0: w[31:26] = msd_pkg::OP_ADDI;
					1: w[31:26] = msd_pkg::OP_ADDIU;
					2: w[31:26] = msd_pkg::OP_SW;
					3: w[31:26] = msd_pkg::OP_LW;
					4: w[31:26] = msd_pkg::OP_J;
					5: w[31:26] = msd_pkg::OP_BEQ;
					6: w[31:26] = msd_pkg::OP_BNE;
					7: w[31:26] = msd_pkg::OP_BGTZ;
					8: w[31:26] = msd_pkg::OP_BLEZ;
					default: w[31:26] = msd_pkg::OP_SLTI;
				endcase
			end
			4: begin
				w[31:26] = msd_pkg::OP_REGIMM;
				case ($urandom_range(0, 2))
					0: w[20:16] = msd_pkg::RT_BGEZ;
					1: w[20:16] = msd_pkg::RT_BLTZ;
					default: ;
				endcase
			end
			5, 6, 7: begin
				w[31:26] = msd_pkg::OP_SPECIAL;
				case ($urandom_range(0, 11))
					0:  w[5:0] = msd_pkg::FN_SLT;
					1:  w[5:0] = msd_pkg::FN_SLTU;
					2:  w[5:0] = msd_pkg::FN_SRL;
					3:  w[5:0] = msd_pkg::FN_SRA;
					4:  w[5:0] = msd_pkg::FN_ADD;
					5:  w[5:0] = msd_pkg::FN_ADDU;
					6:  w[5:0] = msd_pkg::FN_SUB;
					7:  w[5:0] = msd_pkg::FN_SUBU;
					8:  w[5:0] = msd_pkg::FN_AND;
					9:  w[5:0] = msd_pkg::FN_OR;
					10: w[5:0] = msd_pkg::FN_XOR;
					default: w[5:0] = msd_pkg::FN_NOR;
				endcase
				if ($urandom_range(0, 7) == 0) w[15:11] = '0;
			end
			8: begin
				// Shift or no-op: each of rt, rd and shift is zero half the time.
				w[31:26] = msd_pkg::OP_SPECIAL;
				w[5:0] = msd_pkg::FN_SLL;
				if ($urandom_range(0, 1) == 0) w[20:16] = '0;
				if ($urandom_range(0, 1) == 0) w[15:11] = '0;
				if ($urandom_range(0, 1) == 0) w[10:6] = '0;
			end
			default: ;
		endcase
		if (classify_word(w) == msd_pkg::KIND_BREAK) w[0] = ~w[0];
		return w;
	endfunction

	// Predicts the result of one accepted word and advances the model state.
	task automatic track_accepted_word(input msd_pkg::word_t w);
		decode_result_t r;
		r.word_address = model_next_address;
		if (model_break_seen) begin
			r.kind          = msd_pkg::KIND_DATA;
			r.rs_field      = '0;
			r.rt_field      = '0;
			r.rd_field      = '0;
			r.shift_amount  = '0;
			r.immediate     = '0;
			r.branch_offset = '0;
			r.jump_target   = '0;
			r.data_value    = (model_next_address > model_threshold) ? w : '0;
			data_words++;
			if (model_next_address > model_threshold) data_above++;
		end else begin
			r.kind          = classify_word(w);
			r.rs_field      = w[25:21];
			r.rt_field      = w[20:16];
			r.rd_field      = w[15:11];
			r.shift_amount  = w[10:6];
			r.immediate     = w[15:0];
			r.branch_offset = {w[15:0], 2'b00};
			r.jump_target   = {model_next_address[31:28], w[25:0], 2'b00};
			r.data_value    = '0;
			decoded_words++;
			// The BREAK word itself is still decoded; only later words are data.
			if (r.kind == msd_pkg::KIND_BREAK) model_break_seen = 1'b1;
		end
		model_next_address = model_next_address + msd_pkg::ADDRESS_STEP;
		pending_results.push_back(r);
	endtask

	// Sends one word. Called and returns at a falling edge. The sender works
	// in bursts: when a burst is used up, it may drop valid for a random gap
	// before the next burst begins. Valid stays high across items of a burst.
	task automatic send_word(input msd_pkg::word_t w);
		int gap;
		if (burst_left == 0) begin
			gap = (no_gaps || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				insn.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		insn.valid <= 1'b1;
		insn.instruction_word <= w;
		do @(posedge clk); while (!insn.ready);
		track_accepted_word(w);
		burst_left--;
		@(negedge clk);
	endtask

	// Ends a batch of words; called at a falling edge right after send_word.
	task automatic stop_words();
		insn.valid <= 1'b0;
		burst_left = 0;
	endtask

	// Waits for every predicted result, then lets the pipeline settle.
	// Returns at a falling edge.
	task automatic drain_results();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (PIPE_LATENCY + 2) @(posedge clk);
		@(negedge clk);
	endtask

	// Writes one configuration register while the decoder is idle.
	task automatic write_register(input msd_pkg::cfg_reg_t idx, input msd_pkg::word_t value);
		drain_results();
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		do @(posedge clk); while (!cfg.ready);
		case (idx)
			msd_pkg::REG_START_ADDRESS: model_next_address = value;
			msd_pkg::REG_DATA_THRESHOLD: model_threshold = value;
			default: ;
		endcase
		register_writes++;
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			error_count++;
		end
	endtask

	// Result receiver. It changes its stall pattern every stretch of random
	// length: always ready, randomly stalling, or stalling on a fixed period.
	// A hold-off request keeps ready low for as long as it asks, without a break.
	initial begin : result_receiver
		rx_mode_t mode;
		int stretch_left;
		int period;
		int phase;
		int hold_left;
		mode = RX_STEADY;
		stretch_left = 0;
		period = 2;
		phase = 0;
		hold_left = 0;
		result.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				result.ready <= 1'b0;
			end else begin
				if (stretch_left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 2));
					stretch_left = $urandom_range(8, 64);
					period = $urandom_range(2, 5);
				end
				stretch_left--;
				phase++;
				case (mode)
					RX_STEADY:   result.ready <= 1'b1;
					RX_RANDOM:   result.ready <= ($urandom_range(0, 2) != 0);
					default:     result.ready <= (phase % period != 0);
				endcase
			end
		end
	end

	// Every accepted result is matched against the oldest prediction.
	always @(posedge clk) begin : result_checker
		decode_result_t want;
		if (arst_n && result.valid && result.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result item with no expectation, kind %0d address %h",
					$time, result.kind, result.word_address);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				compare_field("kind", 32'(want.kind), 32'(result.kind));
				compare_field("word_address", want.word_address, result.word_address);
				compare_field("rs_field", 32'(want.rs_field), 32'(result.rs_field));
				compare_field("rt_field", 32'(want.rt_field), 32'(result.rt_field));
				compare_field("rd_field", 32'(want.rd_field), 32'(result.rd_field));
				compare_field("shift_amount", 32'(want.shift_amount),
					32'(result.shift_amount));
				compare_field("immediate", 32'(want.immediate), 32'(result.immediate));
				compare_field("branch_offset", 32'(want.branch_offset),
					32'(result.branch_offset));
				compare_field("jump_target", want.jump_target, result.jump_target);
				compare_field("data_value", want.data_value, result.data_value);
			end
		end
	end

	// One word of each instruction kind but BREAK, at the reset start address,
	// with field extremes and the corner cases of the special and regimm groups.
	task automatic test_opcode_table();
		send_word(itype(msd_pkg::OP_ADDI, 5'd31, 5'd0, 16'h7FFF));
		send_word(itype(msd_pkg::OP_ADDIU, 5'd0, 5'd31, 16'h8000));
		send_word(itype(msd_pkg::OP_SW, 5'd29, 5'd8, 16'hFFFC));
		send_word(itype(msd_pkg::OP_LW, 5'd5, 5'd6, 16'h0004));
		send_word({msd_pkg::OP_J, 26'h3FF_FFFF});
		send_word(itype(msd_pkg::OP_BEQ, 5'd1, 5'd2, 16'hFFFF));
		send_word(itype(msd_pkg::OP_BNE, 5'd3, 5'd4, 16'h0001));
		send_word(itype(msd_pkg::OP_REGIMM, 5'd7, msd_pkg::RT_BGEZ, 16'h8000));
		send_word(itype(msd_pkg::OP_REGIMM, 5'd7, msd_pkg::RT_BLTZ, 16'h7FFF));
		// A regimm selector other than BGEZ or BLTZ is unknown.
		send_word(itype(msd_pkg::OP_REGIMM, 5'd7, 5'd2, 16'h0000));
		send_word(itype(msd_pkg::OP_BGTZ, 5'd9, 5'd0, 16'h0010));
		send_word(itype(msd_pkg::OP_BLEZ, 5'd9, 5'd0, 16'hFFF0));
		send_word(itype(msd_pkg::OP_SLTI, 5'd10, 5'd11, 16'h8001));
		send_word(rtype(5'd1, 5'd2, 5'd0, 5'd0, msd_pkg::FN_SLT));
		send_word(rtype(5'd4, 5'd5, 5'd6, 5'd0, msd_pkg::FN_SLTU));
		send_word(rtype(5'd0, 5'd1, 5'd2, 5'd31, msd_pkg::FN_SLL));
		// All-zero word is a no-op, and so is function zero with only rs set.
		send_word(32'h0000_0000);
		send_word(rtype(5'd31, 5'd0, 5'd0, 5'd0, msd_pkg::FN_SLL));
		send_word(rtype(5'd1, 5'd2, 5'd3, 5'd4, msd_pkg::FN_SRL));
		// Register forms other than SLL, SLT, SLTU and BREAK are unknown with a zero destination.
		send_word(rtype(5'd1, 5'd2, 5'd0, 5'd4, msd_pkg::FN_SRL));
		send_word(rtype(5'd31, 5'd31, 5'd31, 5'd31, msd_pkg::FN_SRA));
		send_word(rtype(5'd8, 5'd9, 5'd10, 5'd0, msd_pkg::FN_SUB));
		send_word(rtype(5'd8, 5'd9, 5'd11, 5'd0, msd_pkg::FN_SUBU));
		send_word(rtype(5'd12, 5'd13, 5'd14, 5'd0, msd_pkg::FN_ADD));
		send_word(rtype(5'd12, 5'd13, 5'd15, 5'd0, msd_pkg::FN_ADDU));
		send_word(rtype(5'd16, 5'd17, 5'd18, 5'd0, msd_pkg::FN_AND));
		send_word(rtype(5'd16, 5'd17, 5'd19, 5'd0, msd_pkg::FN_OR));
		send_word(rtype(5'd20, 5'd21, 5'd22, 5'd0, msd_pkg::FN_XOR));
		send_word(rtype(5'd20, 5'd21, 5'd23, 5'd0, msd_pkg::FN_NOR));
		send_word(32'hFFFF_FFFF);
		stop_words();
	endtask

	// Addresses run across the top of the 32-bit space and wrap to zero.
	task automatic test_address_wrap();
		write_register(msd_pkg::REG_START_ADDRESS, 32'hFFFF_FFF0);
		repeat (8) send_word(random_instruction());
		send_word({msd_pkg::OP_J, 26'h155_5555});
		stop_words();
		write_register(msd_pkg::REG_START_ADDRESS, 32'hFFFF_FFFC);
		repeat (3) send_word(random_instruction());
		stop_words();
	endtask

	// Random instruction stream from a new start address each chunk, so the
	// jump target sees many upper address nibbles.
	task automatic test_random_decode();
		for (int chunk = 0; chunk < 7; chunk++) begin
			write_register(msd_pkg::REG_START_ADDRESS,
				(chunk == 0) ? 32'h0 : ($urandom() & 32'hFFFF_FFFC));
			repeat (100) send_word(random_instruction());
			stop_words();
		end
	endtask

	// The receiver holds off for a long stretch while words keep coming,
	// which fills both pipeline stages and stalls the input.
	task automatic test_result_backpressure();
		drain_results();
		no_gaps = 1'b1;
		hold_request = PRESSURE_HOLD;
		repeat (40) send_word(random_instruction());
		stop_words();
		no_gaps = 1'b0;
	endtask

	// BREAK ends decode mode. The data words that follow straddle the reset
	// threshold of 700; the word at exactly 700 must still read as zero.
	task automatic test_break_entry();
		msd_pkg::word_t brk;
		brk = $urandom();
		brk[31:26] = msd_pkg::OP_SPECIAL;
		brk[5:0] = msd_pkg::FN_BREAK;
		write_register(msd_pkg::REG_START_ADDRESS, 32'd680);
		repeat (4) send_word(random_instruction());
		send_word(brk);
		send_word(32'h7FFF_FFFF);
		send_word(32'h8000_0000);
		send_word(32'hFFFF_FFFF);
		send_word(32'h0000_0000);
		send_word(brk);
		repeat (6) send_word($urandom());
		stop_words();
	endtask

	// Data mode under a range of thresholds, including both extremes and an
	// address wrap past the threshold.
	task automatic test_data_thresholds();
		msd_pkg::word_t start;
		write_register(msd_pkg::REG_DATA_THRESHOLD, 32'h0);
		write_register(msd_pkg::REG_START_ADDRESS, 32'h0);
		repeat (30) send_word($urandom());
		stop_words();
		write_register(msd_pkg::REG_DATA_THRESHOLD, 32'hFFFF_FFFF);
		write_register(msd_pkg::REG_START_ADDRESS, $urandom() & 32'hFFFF_FFFC);
		repeat (30) send_word($urandom());
		stop_words();
		write_register(msd_pkg::REG_DATA_THRESHOLD, 32'hFFFF_FFF0);
		write_register(msd_pkg::REG_START_ADDRESS, 32'hFFFF_FFE0);
		repeat (20) send_word($urandom());
		stop_words();
		for (int set = 0; set < 8; set++) begin
			start = $urandom() & 32'hFFFF_FFFC;
			write_register(msd_pkg::REG_START_ADDRESS, start);
			write_register(msd_pkg::REG_DATA_THRESHOLD, start + 4 * $urandom_range(0, 40)
				+ $urandom_range(0, 3));
			repeat (40) send_word($urandom());
			stop_words();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		insn.valid = 1'b0;
		insn.instruction_word = '0;
		cfg.valid = 1'b0;
		cfg.index = msd_pkg::REG_START_ADDRESS;
		cfg.data = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_opcode_table();
		test_address_wrap();
		test_random_decode();
		test_result_backpressure();
		test_break_entry();
		test_data_thresholds();

		drain_results();
		$display("tb: %0d results checked: %0d decoded words, %0d data words",
			results_checked, decoded_words, data_words);
		$display("tb: %0d data words above threshold, %0d register writes, %0d-cycle hold-off",
			data_above, register_writes, PRESSURE_HOLD);
		if (error_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
